// ----- rtl/tt_pkg.sv -----
package tt_pkg;

  // Port field widths
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  typedef logic [COL_W-1:0]  col_port_t;
  typedef logic [ROW_W-1:0]  row_port_t;
  typedef logic [CELL_W-1:0] cell_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [ATTR_W-1:0] COLOR_RESET  = 8'h07;
  localparam cell_t             CELL_RESET   = 16'h0720;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_LD_COPY,
    CNT_LD_FILL
  } cnt_cmd_t;

  typedef struct packed {
    logic     accept;
    logic     clear_wr;
    cnt_cmd_t cnt;
    logic     copy_rd;
    logic     fill_wr;
    logic     scroll_done;
    logic     put;
    logic     cell_wr;
    logic     cell_rd;
    logic     out_load;
  } tt_cmd_t;

  typedef struct packed {
    op_t  op;
    logic scroll_pend;
    logic in_range;
    logic cnt_last;
    logic out_full;
  } tt_sts_t;

endpackage

// ----- rtl/text_terminal_char_writer.sv -----
// Text-mode terminal: a COLS x ROWS screen of 16-bit cells (character in the
// low byte, attribute in the high byte) with a cursor. Op 0 puts a character
// at the cursor (newline, backspace, wrap at the last column, and a one-line
// scroll first when the cursor sits below the bottom row), op 1 writes a cell,
// op 2 reads one; every word returns one result with the cursor position.
// After reset the block sweeps the whole store to blank grey on black, one
// cell per cycle, so in_ready stays low until the sweep is done; cfg writes
// are taken during that time as always. Afterwards an op 1/2/3 or a plain
// op 0 steps through accept, store access and result load; the load waits
// while the result register is full and out_ready is low. The next word is
// accepted right after the result is loaded, even if out_ready is still low.
// A scroll adds a copy, a copy tail and a fill of the bottom line before the
// put: the store has one read and one write port and the copy moves one cell
// per cycle, then the bottom line is blanked one cell per cycle. cfg_ready is
// always high; write text_color only while idle.
module text_terminal_char_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // attribute register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tt_pkg::ATTR_W-1:0] cfg_text_color,
  // command words
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tt_pkg::OP_W-1:0]   in_op,
  input  logic [tt_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tt_pkg::ATTR_W-1:0] in_cell_color,
  input  logic [tt_pkg::COL_W-1:0]  in_cell_col,
  input  logic [tt_pkg::ROW_W-1:0]  in_cell_row,
  // result words
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tt_pkg::ROW_W-1:0]  out_cursor_row,
  output logic [tt_pkg::COL_W-1:0]  out_cursor_col,
  output logic [tt_pkg::CELL_W-1:0] out_cell_value,
  output logic                      out_did_scroll
);

  tt_pkg::tt_cmd_t cmd;
  tt_pkg::tt_sts_t sts;

  // the user keeps register writes clear of the datapath use of the color; the block does not enforce it
  assign cfg_ready = 1'b1;

  // sequencer: clear sweep, dispatch, scroll copy/fill, result hand-off
  tt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // cursor, attribute, address calc, screen store and result register
  tt_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_text_color (cfg_text_color),
    .in_op          (in_op),
    .in_char_code   (in_char_code),
    .in_cell_color  (in_cell_color),
    .in_cell_col    (in_cell_col),
    .in_cell_row    (in_cell_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cell_value (out_cell_value),
    .out_did_scroll (out_did_scroll)
  );

endmodule

// ----- rtl/tt_ram.sv -----
module tt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tt_ctrl.sv -----
module tt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tt_pkg::tt_sts_t  sts,
  output tt_pkg::tt_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_COPY,
    ST_COPY_TAIL,
    ST_FILL,
    ST_PUT,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.cnt   = tt_pkg::CNT_HOLD;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.cnt = tt_pkg::CNT_INC;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = ST_DONE;
        case (sts.op)
          tt_pkg::OP_PUT: begin
            if (sts.scroll_pend) begin
              cmd.cnt   = tt_pkg::CNT_LD_COPY;
              state_nxt = ST_COPY;
            end else begin
              cmd.put = 1'b1;
            end
          end
          tt_pkg::OP_WRITE: cmd.cell_wr = sts.in_range;
          tt_pkg::OP_READ:  cmd.cell_rd = sts.in_range;
          default: ;
        endcase
      end
      ST_COPY: begin
        cmd.copy_rd = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = ST_COPY_TAIL;
        end else begin
          cmd.cnt = tt_pkg::CNT_INC;
        end
      end
      ST_COPY_TAIL: begin
        // last copied word lands this cycle
        cmd.cnt   = tt_pkg::CNT_LD_FILL;
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill_wr = 1'b1;
        if (sts.cnt_last) begin
          cmd.scroll_done = 1'b1;
          state_nxt       = ST_PUT;
        end else begin
          cmd.cnt = tt_pkg::CNT_INC;
        end
      end
      ST_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

`ifndef NO_ASSERTIONS
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == ST_DISPATCH)
    else $error("accepted word not dispatched");
`endif

endmodule

// ----- rtl/tt_dp.sv -----
module tt_dp #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tt_pkg::tt_cmd_t          cmd,
  output tt_pkg::tt_sts_t          sts,
  input  logic                     cfg_we,
  input  logic [tt_pkg::ATTR_W-1:0] cfg_text_color,
  input  logic [tt_pkg::OP_W-1:0]   in_op,
  input  logic [tt_pkg::CHAR_W-1:0] in_char_code,
  input  logic [tt_pkg::ATTR_W-1:0] in_cell_color,
  input  logic [tt_pkg::COL_W-1:0]  in_cell_col,
  input  logic [tt_pkg::ROW_W-1:0]  in_cell_row,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [tt_pkg::ROW_W-1:0]  out_cursor_row,
  output logic [tt_pkg::COL_W-1:0]  out_cursor_col,
  output logic [tt_pkg::CELL_W-1:0] out_cell_value,
  output logic                     out_did_scroll
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS + 1);
  localparam logic [15:0]   COLS_16   = 16'(COLS);
  localparam logic [8:0]    COLS_L    = 9'(COLS);
  localparam logic [7:0]    ROWS_L    = 8'(ROWS);
  localparam logic [AW-1:0] CNT_LAST  = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_BASE = AW'(COLS);
  localparam logic [AW-1:0] FILL_BASE = AW'(COLS * (ROWS - 1));
  localparam logic [RW-1:0] ROW_PEND  = RW'(ROWS);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);

  logic [RW-1:0]             cur_row_r;
  logic [CW-1:0]             cur_col_r;
  logic [tt_pkg::ATTR_W-1:0] color_r;
  tt_pkg::op_t               op_r;
  logic [tt_pkg::CHAR_W-1:0] ch_r;
  logic [tt_pkg::ATTR_W-1:0] attr_r;
  logic [AW-1:0]             addr_r;
  logic                      in_range_r;
  logic [AW-1:0]             cnt_r;
  logic                      pend_r;
  logic [AW-1:0]             wa_r;
  logic                      scrolled_r;
  logic                      out_valid_r;
  tt_pkg::row_port_t         out_row_r;
  tt_pkg::col_port_t         out_col_r;
  tt_pkg::cell_t             out_value_r;
  logic                      out_scroll_r;

  logic          scroll_pend;
  logic [7:0]    rsel;
  logic [7:0]    csel;
  logic [15:0]   addr_calc;
  logic          put_wr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  tt_pkg::cell_t ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  tt_pkg::cell_t ram_rdata;

  assign scroll_pend = (cur_row_r == ROW_PEND);

  // one address multiply: cursor position for puts, given position otherwise
  always_comb begin
    if (tt_pkg::op_t'(in_op) == tt_pkg::OP_PUT) begin
      rsel = scroll_pend ? 8'(ROW_LAST) : 8'(cur_row_r);
      csel = (in_char_code == tt_pkg::CH_BACKSPACE) ? 8'(cur_col_r) - 8'd1 : 8'(cur_col_r);
    end else begin
      rsel = 8'(in_cell_row);
      csel = 8'(in_cell_col);
    end
    addr_calc = 16'(rsel) * COLS_16 + 16'(csel);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r       <= tt_pkg::op_t'(in_op);
      ch_r       <= in_char_code;
      attr_r     <= in_cell_color;
      addr_r     <= addr_calc[AW-1:0];
      in_range_r <= (9'(in_cell_col) < COLS_L) && (8'(in_cell_row) < ROWS_L);
    end
    wa_r <= cnt_r - COPY_BASE;
  end

  // cursor, color, scroll flag, sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      color_r    <= tt_pkg::COLOR_RESET;
      cnt_r      <= '0;
      pend_r     <= 1'b0;
      scrolled_r <= 1'b0;
    end else begin
      pend_r <= cmd.copy_rd;
      if (cfg_we) begin
        color_r <= cfg_text_color;
      end
      case (cmd.cnt)
        tt_pkg::CNT_INC:     cnt_r <= cnt_r + 1'b1;
        tt_pkg::CNT_LD_COPY: cnt_r <= COPY_BASE;
        tt_pkg::CNT_LD_FILL: cnt_r <= FILL_BASE;
        default: ;
      endcase
      if (cmd.accept) begin
        scrolled_r <= 1'b0;
      end
      if (cmd.scroll_done) begin
        scrolled_r <= 1'b1;
        cur_row_r  <= ROW_LAST;
      end
      if (cmd.put) begin
        if (ch_r == tt_pkg::CH_NEWLINE) begin
          cur_row_r <= cur_row_r + 1'b1;
          cur_col_r <= '0;
        end else if (ch_r == tt_pkg::CH_BACKSPACE) begin
          if (cur_col_r != '0) begin
            cur_col_r <= cur_col_r - 1'b1;
          end
        end else if (cur_col_r == COL_LAST) begin
          cur_col_r <= '0;
          cur_row_r <= cur_row_r + 1'b1;
        end else begin
          cur_col_r <= cur_col_r + 1'b1;
        end
      end
    end
  end

  assign put_wr = cmd.put && (ch_r != tt_pkg::CH_NEWLINE) &&
                  !((ch_r == tt_pkg::CH_BACKSPACE) && (cur_col_r == '0));

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = addr_r;
    ram_wdata = {attr_r, ch_r};
    if (cmd.clear_wr) begin
      ram_waddr = cnt_r;
      ram_wdata = tt_pkg::CELL_RESET;
    end else if (cmd.fill_wr) begin
      ram_waddr = cnt_r;
      ram_wdata = {color_r, tt_pkg::CH_BLANK};
    end else if (pend_r) begin
      ram_waddr = wa_r;
      ram_wdata = ram_rdata;
    end else if (cmd.cell_wr) begin
      ram_wdata = {attr_r, ch_r};
    end else if (put_wr) begin
      ram_wdata = (ch_r == tt_pkg::CH_BACKSPACE) ? {color_r, tt_pkg::CH_BLANK}
                                                 : {color_r, ch_r};
    end else begin
      ram_we = 1'b0;
    end
  end

  assign ram_re    = cmd.copy_rd || cmd.cell_rd;
  assign ram_raddr = cmd.copy_rd ? cnt_r : addr_r;

  tt_ram #(
    .WIDTH (tt_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row_r    <= tt_pkg::row_port_t'(cur_row_r);
      out_col_r    <= tt_pkg::col_port_t'(cur_col_r);
      out_value_r  <= (op_r == tt_pkg::OP_READ && in_range_r) ? ram_rdata : '0;
      out_scroll_r <= scrolled_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_cell_value = out_value_r;
  assign out_did_scroll = out_scroll_r;

  always_comb begin
    sts             = '0;
    sts.op          = op_r;
    sts.scroll_pend = scroll_pend;
    sts.in_range    = in_range_r;
    sts.cnt_last    = (cnt_r == CNT_LAST);
    sts.out_full    = out_valid_r && !out_ready;
  end

`ifndef NO_ASSERTIONS
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_wr, cmd.fill_wr, pend_r, cmd.cell_wr, put_wr}))
    else $error("store write collision");
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scroll_done |=> (cur_row_r == ROW_LAST) && scrolled_r)
    else $error("scroll did not settle cursor");
  a_print_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put && (ch_r != tt_pkg::CH_NEWLINE) && (ch_r != tt_pkg::CH_BACKSPACE)
    |=> cur_col_r != $past(cur_col_r))
    else $error("cursor did not advance on character");
  a_pend_col0: assert property (@(posedge clk) disable iff (!rst_n)
    scroll_pend |-> cur_col_r == '0)
    else $error("scroll pending away from column 0");
`endif

endmodule

// ----- bench/tb_text_terminal_char_writer.sv -----
module tb_text_terminal_char_writer;
  timeunit 1ns;
  timeprecision 1ps;

  // Screen geometry, kept equal to the block's defaults
  localparam int COLS = 80;
  localparam int ROWS = 25;

  // Random part: six chunks, one text_color setting per chunk
  localparam int N_CHUNKS    = 6;
  localparam int CHUNK_WORDS = 50;
  // Receiver hold-off used to back the block up into its input
  localparam int HOLD_CYCLES = 300;
  // Idle cycles before a cfg write and after the last result
  localparam int SETTLE_CYCLES = 8;

  // One command word, one field per port
  typedef struct packed {
    tt_pkg::op_t               op;
    logic [tt_pkg::CHAR_W-1:0] ch;
    logic [tt_pkg::ATTR_W-1:0] color;
    tt_pkg::col_port_t         col;
    tt_pkg::row_port_t         row;
  } word_t;

  // One result word
  typedef struct packed {
    tt_pkg::row_port_t row;
    tt_pkg::col_port_t col;
    tt_pkg::cell_t     value;
    logic              scroll;
  } report_t;

  // Directed table row: word, repeat count, and an optional hand-typed result
  typedef struct {
    word_t   w;
    int      reps;
    bit      typed;
    report_t want;
  } dir_row_t;

  logic                         clk;
  logic                         rst_n          = 1'b0;
  logic                         cfg_valid      = 1'b0;
  logic                         cfg_ready;
  logic [tt_pkg::ATTR_W-1:0]    cfg_text_color = '0;
  logic                         in_valid       = 1'b0;
  logic                         in_ready;
  logic [tt_pkg::OP_W-1:0]      in_op          = '0;
  logic [tt_pkg::CHAR_W-1:0]    in_char_code   = '0;
  logic [tt_pkg::ATTR_W-1:0]    in_cell_color  = '0;
  logic [tt_pkg::COL_W-1:0]     in_cell_col    = '0;
  logic [tt_pkg::ROW_W-1:0]     in_cell_row    = '0;
  logic                         out_valid;
  logic                         out_ready      = 1'b0;
  logic [tt_pkg::ROW_W-1:0]     out_cursor_row;
  logic [tt_pkg::COL_W-1:0]     out_cursor_col;
  logic [tt_pkg::CELL_W-1:0]    out_cell_value;
  logic                         out_did_scroll;

  text_terminal_char_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_text_color (cfg_text_color),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_char_code   (in_char_code),
    .in_cell_color  (in_cell_color),
    .in_cell_col    (in_cell_col),
    .in_cell_row    (in_cell_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_cell_value (out_cell_value),
    .out_did_scroll (out_did_scroll)
  );

  // ---------------------------------------------------------------------------
  // Terminal mirror: screen image, cursor and attribute register
  // ---------------------------------------------------------------------------
  tt_pkg::cell_t  screen_img [COLS*ROWS];
  int             crow;
  int             ccol;
  logic [7:0]     attr_reg;

  // Expected result words, oldest first
  report_t        cursor_reports[$];
  dir_row_t       dir_rows[$];

  int             err_count   = 0;
  int             n_words     = 0;
  int             n_scrolls   = 0;
  int             n_results   = 0;
  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  bit             rx_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs; far above a run where every word scrolls
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Applies one word to the mirror and returns the result it must produce.
  function automatic report_t emulate_terminal(word_t w);
    report_t r;
    int      i;
    r = '0;
    case (w.op)
      tt_pkg::OP_PUT: begin
        // cursor parked below the bottom row: scroll one line first
        if (crow >= ROWS) begin
          for (i = 0; i < COLS*(ROWS-1); i++)
            screen_img[i] = screen_img[i+COLS];
          for (i = 0; i < COLS; i++)
            screen_img[COLS*(ROWS-1)+i] = {attr_reg, tt_pkg::CH_BLANK};
          crow     = ROWS - 1;
          r.scroll = 1'b1;
        end
        if (w.ch == tt_pkg::CH_NEWLINE) begin
          crow++;
          ccol = 0;
        end else if (w.ch == tt_pkg::CH_BACKSPACE) begin
          // at column 0 a backspace is a no-op
          if (ccol > 0) begin
            ccol--;
            screen_img[crow*COLS+ccol] = {attr_reg, tt_pkg::CH_BLANK};
          end
        end else begin
          screen_img[crow*COLS+ccol] = {attr_reg, w.ch};
          ccol++;
          // wrap: next row, may leave a scroll pending
          if (ccol >= COLS) begin
            ccol = 0;
            crow++;
          end
        end
      end
      tt_pkg::OP_WRITE: begin
        if (w.col < COLS && w.row < ROWS)
          screen_img[w.row*COLS+w.col] = {w.color, w.ch};
      end
      tt_pkg::OP_READ: begin
        if (w.col < COLS && w.row < ROWS)
          r.value = screen_img[w.row*COLS+w.col];
      end
      default: ;
    endcase
    r.row = tt_pkg::row_port_t'(crow);
    r.col = tt_pkg::col_port_t'(ccol);
    return r;
  endfunction

  // Random word: mostly character traffic with enough newlines to keep
  // the cursor at the bottom, so scrolls keep happening.
  function automatic word_t random_word();
    word_t w;
    int    roll;
    w.ch    = 8'($urandom_range(255));
    w.color = 8'($urandom_range(255));
    // mostly in-range positions, some anywhere in the field width
    if ($urandom_range(99) < 85) begin
      w.col = tt_pkg::col_port_t'($urandom_range(COLS-1));
      w.row = tt_pkg::row_port_t'($urandom_range(ROWS-1));
    end else begin
      w.col = tt_pkg::col_port_t'($urandom);
      w.row = tt_pkg::row_port_t'($urandom);
    end
    roll = $urandom_range(99);
    if (roll < 60) begin
      w.op = tt_pkg::OP_PUT;
      roll = $urandom_range(99);
      if (roll < 15)
        w.ch = tt_pkg::CH_NEWLINE;
      else if (roll < 23)
        w.ch = tt_pkg::CH_BACKSPACE;
    end else if (roll < 75) begin
      w.op = tt_pkg::OP_WRITE;
    end else if (roll < 95) begin
      w.op = tt_pkg::OP_READ;
    end else begin
      w.op = tt_pkg::OP_NONE;
    end
    return w;
  endfunction

  function automatic word_t mk_word(tt_pkg::op_t op, logic [7:0] ch, logic [7:0] color,
                                    int col, int row);
    word_t w;
    w.op    = op;
    w.ch    = ch;
    w.color = color;
    w.col   = tt_pkg::col_port_t'(col);
    w.row   = tt_pkg::row_port_t'(row);
    return w;
  endfunction

  task automatic add_row(input word_t w, input int reps, input bit typed,
                         input report_t want);
    dir_row_t d;
    d.w     = w;
    d.reps  = reps;
    d.typed = typed;
    d.want  = want;
    dir_rows.push_back(d);
  endtask

  task automatic flag_mismatch(input string field, input int want, input int got);
    err_count++;
    $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
  endtask

  // Offers one word, waits for the handshake, then records its result.
  task automatic send_word(input word_t w, input bit typed, input report_t want);
    int      gap;
    report_t r;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= w.op;
    in_char_code  <= w.ch;
    in_cell_color <= w.color;
    in_cell_col   <= w.col;
    in_cell_row   <= w.row;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    r = emulate_terminal(w);
    if (r.scroll)
      n_scrolls++;
    cursor_reports.push_back(typed ? want : r);
    n_words++;
  endtask

  // Drop valid, wait for every outstanding result, then a few quiet cycles.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (cursor_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_color(input logic [7:0] v);
    cfg_valid      <= 1'b1;
    cfg_text_color <= v;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    attr_reg = v;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: checks each accepted word, then picks out_ready for the next
  // edge. A hold request from the stimulus turns into a long counted stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_side
    report_t want;
    int      hold_left;
    if (rx_hold_req) begin
      hold_left   = HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    if (out_valid && out_ready) begin
      n_results++;
      if (cursor_reports.size() == 0) begin
        err_count++;
        $error("result word with nothing expected");
      end else begin
        want = cursor_reports.pop_front();
        if (out_cursor_row !== want.row)
          flag_mismatch("cursor_row", want.row, out_cursor_row);
        if (out_cursor_col !== want.col)
          flag_mismatch("cursor_col", want.col, out_cursor_col);
        if (out_cell_value !== want.value)
          flag_mismatch("cell_value", want.value, out_cell_value);
        if (out_did_scroll !== want.scroll)
          flag_mismatch("did_scroll", want.scroll, out_did_scroll);
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int         c;
    int         k;
    logic [7:0] color;
    for (k = 0; k < COLS*ROWS; k++)
      screen_img[k] = tt_pkg::CELL_RESET;
    crow     = 0;
    ccol     = 0;
    attr_reg = tt_pkg::COLOR_RESET;

    // Directed table. Hand-typed results: the cleared screen, out-of-range
    // reads and the unused op; everything else comes from the mirror.
    add_row(mk_word(tt_pkg::OP_READ, 8'h00, 8'h00, 0, 0), 1, 1'b1,
            '{row: 0, col: 0, value: tt_pkg::CELL_RESET, scroll: 1'b0});
    add_row(mk_word(tt_pkg::OP_READ, 8'hFF, 8'hFF, COLS-1, ROWS-1), 1, 1'b1,
            '{row: 0, col: 0, value: tt_pkg::CELL_RESET, scroll: 1'b0});
    add_row(mk_word(tt_pkg::OP_READ, 8'h00, 8'h00, 127, 31), 1, 1'b1,
            '{row: 0, col: 0, value: 16'h0000, scroll: 1'b0});
    add_row(mk_word(tt_pkg::OP_NONE, 8'hFF, 8'hFF, 127, 31), 1, 1'b1,
            '{row: 0, col: 0, value: 16'h0000, scroll: 1'b0});
    // direct writes: corner cell with all ones, then off-screen writes ignored
    add_row(mk_word(tt_pkg::OP_WRITE, 8'hFF, 8'hFF, 0, 0), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_WRITE, 8'h55, 8'hAA, COLS, ROWS-1), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_WRITE, 8'h55, 8'hAA, 0, ROWS), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_READ, 8'h00, 8'h00, 0, 0), 1, 1'b0, '0);
    // character traffic: put, backspace, backspace at column 0, byte extremes
    add_row(mk_word(tt_pkg::OP_PUT, 8'h41, 8'h00, 0, 0), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_READ, 8'h00, 8'h00, 0, 0), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_PUT, tt_pkg::CH_BACKSPACE, 8'h00, 0, 0), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_PUT, tt_pkg::CH_BACKSPACE, 8'h00, 0, 0), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_PUT, 8'h00, 8'h00, 0, 0), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_PUT, 8'hFF, 8'h00, 0, 0), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_PUT, tt_pkg::CH_NEWLINE, 8'h00, 0, 0), 1, 1'b0, '0);
    // fill a whole line to hit the last-column wrap
    add_row(mk_word(tt_pkg::OP_PUT, 8'h5A, 8'h00, 0, 0), COLS, 1'b0, '0);
    // newlines down past the bottom row, then a backspace that scrolls
    add_row(mk_word(tt_pkg::OP_PUT, tt_pkg::CH_NEWLINE, 8'h00, 0, 0), ROWS-2, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_PUT, tt_pkg::CH_BACKSPACE, 8'h00, 0, 0), 1, 1'b0, '0);
    // a full bottom line wraps into a pending scroll
    add_row(mk_word(tt_pkg::OP_PUT, 8'h61, 8'h00, 0, 0), COLS, 1'b0, '0);
    // direct write and read while the scroll is pending
    add_row(mk_word(tt_pkg::OP_WRITE, 8'h7E, 8'h3C, 5, ROWS-1), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_READ, 8'h00, 8'h00, COLS-1, ROWS-1), 1, 1'b0, '0);
    // newline that scrolls and leaves another scroll pending
    add_row(mk_word(tt_pkg::OP_PUT, tt_pkg::CH_NEWLINE, 8'h00, 0, 0), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_PUT, 8'h42, 8'h00, 0, 0), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_READ, 8'h00, 8'h00, 5, ROWS-2), 1, 1'b0, '0);
    add_row(mk_word(tt_pkg::OP_READ, 8'h00, 8'h00, 0, ROWS-1), 1, 1'b0, '0);

    // Reset once, then the block sweeps the store; in_ready gates the sender.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 17;
    rx_idle_pct = 79;
    foreach (dir_rows[i])
      for (k = 0; k < dir_rows[i].reps; k++)
        send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

    // Random chunks: new colour each time, idle pattern changes every two.
    for (c = 0; c < N_CHUNKS; c++) begin
      settle();
      case (c)
        0:       color = 8'h00;
        1:       color = 8'hFF;
        4:       color = 8'h1F;
        default: color = 8'($urandom_range(255));
      endcase
      write_color(color);
      if (c < 2) begin
        tx_idle_pct = 17;
        rx_idle_pct = 79;
      end else if (c < 4) begin
        tx_idle_pct = 79;
        rx_idle_pct = 17;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // long receiver stall with the sender flat out: input must back up
      if (c == 4)
        rx_hold_req = 1'b1;
      for (k = 0; k < CHUNK_WORDS; k++)
        send_word(random_word(), 1'b0, '0);
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d command words (%0d scrolls), checked %0d results", n_words,
             n_scrolls, n_results);
    $display("Covered %0d text_color settings and three idle patterns", N_CHUNKS + 1);
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
